### rtl/lbc_pkg.sv
// shared types and constants for the parametric line clipper
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

   localparam int unsigned COORD_W = 24;
   localparam int unsigned REG_W = 12;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned EDGES = 4;
   localparam int unsigned DEF_COORD_FRAC_BITS = 8;
   localparam int unsigned DEF_PARAM_FRAC_BITS = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_LEFT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_TOP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_RIGHT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_BOTTOM = 2'd3;

   localparam logic [REG_W-1:0] RESET_CLIP_LEFT = 12'd0;
   localparam logic [REG_W-1:0] RESET_CLIP_TOP = 12'd0;
   localparam logic [REG_W-1:0] RESET_CLIP_RIGHT = 12'd640;
   localparam logic [REG_W-1:0] RESET_CLIP_BOTTOM = 12'd480;

   localparam logic [1:0] EDGE_SKIP = 2'd0;
   localparam logic [1:0] EDGE_REJECT = 2'd1;
   localparam logic [1:0] EDGE_ENTER = 2'd2;
   localparam logic [1:0] EDGE_LEAVE = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic rejected;
      logic signed [COORD_W-1:0] clipped_start_x;
      logic signed [COORD_W-1:0] clipped_start_y;
      logic signed [COORD_W-1:0] clipped_end_x;
      logic signed [COORD_W-1:0] clipped_end_y;
   } rsp_type;

   typedef struct packed {
      logic [EDGES-1:0][1:0] kind;
      logic signed [COORD_W:0] dx;
      logic signed [COORD_W:0] dy;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
   } side_type;

endpackage

`default_nettype wire

### rtl/lbc_div.sv
// pipelined restoring divider lanes, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module lbc_div #(
   parameter int unsigned DEN_W = 25,
   parameter int unsigned PARAM_FRAC_BITS = 16,
   parameter int unsigned LANES = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [LANES-1:0][DEN_W-1:0] in_num,
   input  logic [LANES-1:0][DEN_W-1:0] in_den,
   input  lbc_pkg::side_type in_side,
   output logic out_valid,
   output logic [LANES-1:0][PARAM_FRAC_BITS:0] out_quo,
   output lbc_pkg::side_type out_side
);
   import lbc_pkg::*;

   localparam int unsigned QW = PARAM_FRAC_BITS + 1;
   localparam int unsigned STAGES = PARAM_FRAC_BITS + 1;

   logic [LANES-1:0][DEN_W-1:0] rem_ff [STAGES];
   logic [LANES-1:0][DEN_W-1:0] den_ff [STAGES];
   logic [LANES-1:0][QW-1:0] quo_ff [STAGES];
   side_type side_ff [STAGES];
   logic valid_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [LANES-1:0][DEN_W-1:0] rem_src;
      logic [LANES-1:0][DEN_W-1:0] den_src;
      logic [LANES-1:0][QW-1:0] quo_src;
      side_type side_src;
      logic valid_src;
      logic [LANES-1:0][DEN_W:0] trial;
      logic [LANES-1:0][DEN_W-1:0] rem_in;
      logic [LANES-1:0][QW-1:0] quo_in;

      if (s == 0) begin : g_head
         assign rem_src = in_num;
         assign den_src = in_den;
         assign quo_src = '0;
         assign side_src = in_side;
         assign valid_src = in_valid;
      end else begin : g_body
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign side_src = side_ff[s-1];
         assign valid_src = valid_ff[s-1];
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (s == 0) begin
               trial[l] = {1'b0, rem_src[l]};
            end else begin
               trial[l] = {rem_src[l], 1'b0};
            end
            if (trial[l] >= {1'b0, den_src[l]}) begin
               rem_in[l] = DEN_W'(trial[l] - {1'b0, den_src[l]});
               quo_in[l] = {quo_src[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[l][DEN_W-1:0];
               quo_in[l] = {quo_src[l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
            quo_ff[s] <= quo_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quo = quo_ff[STAGES-1];
   assign out_side = side_ff[STAGES-1];

endmodule

`default_nettype wire

### rtl/parametric_line_clipper.sv
// top level of the parametric line clipper
`timescale 1ns / 1ps
`default_nettype none

// Clips one segment per clock against the rectangle in the four clip registers
// (Liang-Barsky) while the pipeline advances. A request passes through the edge
// setup register, the divider lanes (one per edge, which settle one quotient bit
// per stage), the entry and exit register, the endpoint offset register and the
// response register, and a new request can be taken every cycle. The whole
// pipeline holds while a response waits and rsp_ready is low. Clip registers
// should be written only while no request is in flight.

module parametric_line_clipper #(
   parameter int unsigned COORD_FRAC_BITS = lbc_pkg::DEF_COORD_FRAC_BITS,
   parameter int unsigned PARAM_FRAC_BITS = lbc_pkg::DEF_PARAM_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  lbc_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output lbc_pkg::rsp_type rsp_payload,
   input  logic csr_we,
   input  logic [lbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lbc_pkg::REG_W-1:0] csr_wdata
);
   import lbc_pkg::*;

   localparam int unsigned BOUND_W = REG_W + COORD_FRAC_BITS;
   localparam int unsigned NUM_W = ((BOUND_W > COORD_W) ? BOUND_W : COORD_W) + 2;
   localparam int unsigned DELTA_W = COORD_W + 1;
   localparam int unsigned QW = PARAM_FRAC_BITS + 1;
   localparam int unsigned PROD_W = QW + 1 + DELTA_W;
   localparam logic [QW-1:0] ONE = QW'(1) << PARAM_FRAC_BITS;
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (PARAM_FRAC_BITS - 1);

   logic [REG_W-1:0] clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;
   logic advance;

   // clip registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff <= RESET_CLIP_LEFT;
         clip_top_ff <= RESET_CLIP_TOP;
         clip_right_ff <= RESET_CLIP_RIGHT;
         clip_bottom_ff <= RESET_CLIP_BOTTOM;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLIP_LEFT: clip_left_ff <= csr_wdata;
            CSR_CLIP_TOP: clip_top_ff <= csr_wdata;
            CSR_CLIP_RIGHT: clip_right_ff <= csr_wdata;
            CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // edge setup
   logic signed [NUM_W-1:0] xlo, xhi, ylo, yhi, x0n, y0n;
   logic signed [DELTA_W-1:0] dx, dy;
   logic signed [EDGES-1:0][NUM_W-1:0] num;
   logic signed [EDGES-1:0][DELTA_W-1:0] den;
   logic signed [NUM_W-1:0] n_val, d_val;
   logic [DELTA_W-1:0] mag;
   logic [EDGES-1:0][DELTA_W-1:0] a_num_in, a_den_in;
   side_type a_side_in;

   always_comb begin
      xlo = $signed(NUM_W'(clip_left_ff) << COORD_FRAC_BITS);
      xhi = $signed(NUM_W'(clip_right_ff) << COORD_FRAC_BITS);
      ylo = $signed(NUM_W'(clip_top_ff) << COORD_FRAC_BITS);
      yhi = $signed(NUM_W'(clip_bottom_ff) << COORD_FRAC_BITS);
      x0n = NUM_W'(req_payload.start_x);
      y0n = NUM_W'(req_payload.start_y);
      dx = DELTA_W'(req_payload.end_x) - DELTA_W'(req_payload.start_x);
      dy = DELTA_W'(req_payload.end_y) - DELTA_W'(req_payload.start_y);
      num[0] = xlo - x0n;
      num[1] = x0n - xhi;
      num[2] = ylo - y0n;
      num[3] = y0n - yhi;
      den[0] = dx;
      den[1] = -dx;
      den[2] = dy;
      den[3] = -dy;
      a_side_in.dx = dx;
      a_side_in.dy = dy;
      a_side_in.x0 = req_payload.start_x;
      a_side_in.y0 = req_payload.start_y;
      a_side_in.kind = '0;
      n_val = '0;
      d_val = '0;
      mag = '0;
      for (int l = 0; l < EDGES; l++) begin
         mag = den[l][DELTA_W-1] ? DELTA_W'(-den[l]) : DELTA_W'(den[l]);
         n_val = den[l][DELTA_W-1] ? -num[l] : num[l];
         d_val = $signed(NUM_W'(mag));
         a_num_in[l] = n_val[DELTA_W-1:0];
         a_den_in[l] = mag;
         if (den[l] == '0) begin
            a_side_in.kind[l] = ($signed(num[l]) > 0) ? EDGE_REJECT : EDGE_SKIP;
         end else if (!den[l][DELTA_W-1]) begin
            if (n_val <= 0) begin
               a_side_in.kind[l] = EDGE_SKIP;
            end else if (n_val > d_val) begin
               a_side_in.kind[l] = EDGE_REJECT;
            end else begin
               a_side_in.kind[l] = EDGE_ENTER;
            end
         end else begin
            if (n_val < 0) begin
               a_side_in.kind[l] = EDGE_REJECT;
            end else if (n_val > d_val) begin
               a_side_in.kind[l] = EDGE_SKIP;
            end else begin
               a_side_in.kind[l] = EDGE_LEAVE;
            end
         end
      end
   end

   logic a_valid_ff;
   logic [EDGES-1:0][DELTA_W-1:0] a_num_ff, a_den_ff;
   side_type a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_num_ff <= a_num_in;
         a_den_ff <= a_den_in;
         a_side_ff <= a_side_in;
      end
   end

   // edge quotients
   logic b_valid;
   logic [EDGES-1:0][QW-1:0] b_quo;
   side_type b_side;

   lbc_div #(
      .DEN_W(DELTA_W),
      .PARAM_FRAC_BITS(PARAM_FRAC_BITS),
      .LANES(EDGES)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .in_valid(a_valid_ff),
      .in_num(a_num_ff),
      .in_den(a_den_ff),
      .in_side(a_side_ff),
      .out_valid(b_valid),
      .out_quo(b_quo),
      .out_side(b_side)
   );

   // entry and exit parameters
   logic [QW-1:0] c_te_in, c_tl_in;
   logic c_reject_in;

   always_comb begin
      c_te_in = '0;
      c_tl_in = ONE;
      c_reject_in = 1'b0;
      for (int l = 0; l < EDGES; l++) begin
         if (b_side.kind[l] == EDGE_REJECT) begin
            c_reject_in = 1'b1;
         end
         if (b_side.kind[l] == EDGE_ENTER && b_quo[l] > c_te_in) begin
            c_te_in = b_quo[l];
         end
         if (b_side.kind[l] == EDGE_LEAVE && b_quo[l] < c_tl_in) begin
            c_tl_in = b_quo[l];
         end
      end
      if (c_te_in > c_tl_in) begin
         c_reject_in = 1'b1;
      end
   end

   logic c_valid_ff, c_reject_ff;
   logic [QW-1:0] c_te_ff, c_tl_ff;
   side_type c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_reject_ff <= c_reject_in;
         c_te_ff <= c_te_in;
         c_tl_ff <= c_tl_in;
         c_side_ff <= b_side;
      end
   end

   // endpoint offsets
   logic signed [PROD_W-1:0] d_sx_in, d_sy_in, d_ex_in, d_ey_in;

   always_comb begin
      d_sx_in = $signed({1'b0, c_te_ff}) * c_side_ff.dx;
      d_sy_in = $signed({1'b0, c_te_ff}) * c_side_ff.dy;
      d_ex_in = $signed({1'b0, c_tl_ff}) * c_side_ff.dx;
      d_ey_in = $signed({1'b0, c_tl_ff}) * c_side_ff.dy;
   end

   logic d_valid_ff, d_reject_ff;
   logic signed [PROD_W-1:0] d_sx_ff, d_sy_ff, d_ex_ff, d_ey_ff;
   logic signed [COORD_W-1:0] d_x0_ff, d_y0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_reject_ff <= c_reject_ff;
         d_sx_ff <= d_sx_in;
         d_sy_ff <= d_sy_in;
         d_ex_ff <= d_ex_in;
         d_ey_ff <= d_ey_in;
         d_x0_ff <= c_side_ff.x0;
         d_y0_ff <= c_side_ff.y0;
      end
   end

   // rounding and final add
   logic signed [PROD_W-1:0] sx_sum, sy_sum, ex_sum, ey_sum;
   rsp_type rsp_in;

   always_comb begin
      sx_sum = ((d_sx_ff + HALF) >>> PARAM_FRAC_BITS) + PROD_W'(d_x0_ff);
      sy_sum = ((d_sy_ff + HALF) >>> PARAM_FRAC_BITS) + PROD_W'(d_y0_ff);
      ex_sum = ((d_ex_ff + HALF) >>> PARAM_FRAC_BITS) + PROD_W'(d_x0_ff);
      ey_sum = ((d_ey_ff + HALF) >>> PARAM_FRAC_BITS) + PROD_W'(d_y0_ff);
      rsp_in.rejected = d_reject_ff;
      if (d_reject_ff) begin
         rsp_in.clipped_start_x = '0;
         rsp_in.clipped_start_y = '0;
         rsp_in.clipped_end_x = '0;
         rsp_in.clipped_end_y = '0;
      end else begin
         rsp_in.clipped_start_x = sx_sum[COORD_W-1:0];
         rsp_in.clipped_start_y = sy_sum[COORD_W-1:0];
         rsp_in.clipped_end_x = ex_sum[COORD_W-1:0];
         rsp_in.clipped_end_y = ey_sum[COORD_W-1:0];
      end
   end

   logic rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.rejected |-> rsp_payload.clipped_start_x == '0
         && rsp_payload.clipped_start_y == '0 && rsp_payload.clipped_end_x == '0
         && rsp_payload.clipped_end_y == '0)
      else $error("rejected response carries nonzero endpoints");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty response register");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(c_te_ff) && $stable(c_tl_ff) && $stable(d_valid_ff))
      else $error("pipeline moved during stall");

endmodule

`default_nettype wire

### sim/tb_parametric_line_clipper.sv
// testbench for the parametric line clipper: random and directed segments checked by a scoreboard
`timescale 1ns / 1ps

module tb_parametric_line_clipper;
   import lbc_pkg::*;

   localparam int CFB = DEF_COORD_FRAC_BITS;
   localparam int PFB = DEF_PARAM_FRAC_BITS;
   localparam longint ONE = longint'(1) << PFB;
   localparam int LATENCY = PFB + 5;
   localparam int CYCLE_LIMIT = 400000;

   class clip_scoreboard;
      rsp_type pending[$];
      logic [REG_W-1:0] rect[4];
      int errors;
      int checked;

      function new();
         rect[CSR_CLIP_LEFT] = RESET_CLIP_LEFT;
         rect[CSR_CLIP_TOP] = RESET_CLIP_TOP;
         rect[CSR_CLIP_RIGHT] = RESET_CLIP_RIGHT;
         rect[CSR_CLIP_BOTTOM] = RESET_CLIP_BOTTOM;
         errors = 0;
         checked = 0;
      endfunction

      function bit narrow(longint den, longint num, ref longint te, ref longint tl);
         longint n, d, q;
         if (den > 0) begin
            n = num; d = den;
            if (n <= 0) return 1;
            if (n > d) return 0;
            q = (n * ONE) / d;
            if (q > tl) return 0;
            if (q > te) te = q;
            return 1;
         end
         if (den < 0) begin
            n = -num; d = -den;
            if (n < 0) return 0;
            if (n > d) return 1;
            q = (n * ONE) / d;
            if (q < te) return 0;
            if (q < tl) tl = q;
            return 1;
         end
         return num <= 0;
      endfunction

      function longint cut(longint t, longint delta);
         longint s;
         s = t * delta + (ONE >> 1);
         if (s >= 0) return s / ONE;
         return -((-s + ONE - 1) / ONE);
      endfunction

      function void note_request(req_type r);
         longint x0, y0, x1, y1, xmin, ymin, xmax, ymax, dx, dy, te, tl;
         longint ox0, oy0, ox1, oy1;
         bit vis;
         rsp_type e;
         x0 = longint'(r.start_x); y0 = longint'(r.start_y);
         x1 = longint'(r.end_x); y1 = longint'(r.end_y);
         xmin = longint'(rect[CSR_CLIP_LEFT]) << CFB;
         ymin = longint'(rect[CSR_CLIP_TOP]) << CFB;
         xmax = longint'(rect[CSR_CLIP_RIGHT]) << CFB;
         ymax = longint'(rect[CSR_CLIP_BOTTOM]) << CFB;
         dx = x1 - x0; dy = y1 - y0;
         ox0 = x0; oy0 = y0; ox1 = x1; oy1 = y1;
         vis = 0;
         if (dx == 0 && dy == 0 && x0 >= xmin && y0 >= ymin && x0 < xmax && y0 < ymax) begin
            vis = 1;
         end else begin
            te = 0; tl = ONE;
            if (narrow(dx, xmin - x0, te, tl) && narrow(-dx, x0 - xmax, te, tl) &&
                narrow(dy, ymin - y0, te, tl) && narrow(-dy, y0 - ymax, te, tl)) begin
               vis = 1;
               if (tl < ONE) begin
                  ox1 = x0 + cut(tl, dx);
                  oy1 = y0 + cut(tl, dy);
               end
               if (te > 0) begin
                  ox0 = x0 + cut(te, dx);
                  oy0 = y0 + cut(te, dy);
               end
            end
         end
         e = '0;
         e.rejected = !vis;
         if (vis) begin
            e.clipped_start_x = ox0[COORD_W-1:0];
            e.clipped_start_y = oy0[COORD_W-1:0];
            e.clipped_end_x = ox1[COORD_W-1:0];
            e.clipped_end_y = oy1[COORD_W-1:0];
         end
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            report("response with nothing pending", 0, 0);
            return;
         end
         e = pending.pop_front();
         if (got.rejected !== e.rejected) report("rejected", got.rejected, e.rejected);
         if (got.clipped_start_x !== e.clipped_start_x)
            report("clipped_start_x", got.clipped_start_x, e.clipped_start_x);
         if (got.clipped_start_y !== e.clipped_start_y)
            report("clipped_start_y", got.clipped_start_y, e.clipped_start_y);
         if (got.clipped_end_x !== e.clipped_end_x)
            report("clipped_end_x", got.clipped_end_x, e.clipped_end_x);
         if (got.clipped_end_y !== e.clipped_end_y)
            report("clipped_end_y", got.clipped_end_y, e.clipped_end_y);
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= 30)
            $display("mismatch %s: got %h want %h (response %0d)", what, got, want, checked);
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_we;
   req_type req_payload;
   rsp_type rsp_payload;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [REG_W-1:0] csr_wdata;

   clip_scoreboard sb;
   int cycles, sent, long_hold;
   bit hold_req;

   parametric_line_clipper DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      sb = new();
      cycles = 0;
      long_hold = 0;
      hold_req = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && req_valid && req_ready) sb.note_request(req_payload);
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_payload);
   end

   // receiver stall pattern, with one long hold on request
   initial begin
      int mode;
      rsp_ready = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 0;
            repeat (80) @(negedge clock);
            long_hold++;
            hold_req = 0;
         end
         mode = (cycles / 300) % 3;
         if (mode == 0) rsp_ready <= 1;
         else if (mode == 1) rsp_ready <= ($urandom_range(0, 3) != 0);
         else rsp_ready <= ($urandom_range(0, 1) == 0);
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [REG_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      sb.rect[idx] = val;
   endtask

   task automatic set_rect(int l, int t, int r, int b);
      write_reg(CSR_CLIP_LEFT, REG_W'(l));
      write_reg(CSR_CLIP_TOP, REG_W'(t));
      write_reg(CSR_CLIP_RIGHT, REG_W'(r));
      write_reg(CSR_CLIP_BOTTOM, REG_W'(b));
      csr_we <= 0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic send(logic [23:0] x0, logic [23:0] y0, logic [23:0] x1, logic [23:0] y1);
      req_valid <= 1;
      req_payload <= {x0, y0, x1, y1};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   function automatic logic [23:0] pick_coord();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 24'($urandom);
      if (k == 1) return ($urandom_range(0, 1)) ? 24'h7fffff : 24'h800000;
      if (k < 6) return 24'($urandom_range(0, 700 << CFB)) - 24'(30 << CFB);
      return 24'($urandom_range(0, 5000 << CFB)) - 24'(500 << CFB);
   endfunction

   task automatic random_burst(int count);
      int left, burst;
      logic [23:0] x0, y0;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && left > 0; i++) begin
            x0 = pick_coord();
            y0 = pick_coord();
            if ($urandom_range(0, 15) == 0) send(x0, y0, x0, y0);
            else if ($urandom_range(0, 15) == 0) send(x0, y0, x0, pick_coord());
            else send(x0, y0, pick_coord(), pick_coord());
            left--;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
      req_valid <= 0;
   endtask

   initial begin
      req_valid = 0;
      req_payload = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      sent = 0;
      reset = 1;
      repeat (6) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // directed: reset rectangle, then extremes
      send(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000);
      send(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
      send(24'h000000, 24'h000000, 24'h000000, 24'h000000);
      send(24'(100 << CFB), 24'(100 << CFB), 24'(100 << CFB), 24'(100 << CFB));
      send(24'(640 << CFB), 24'(200 << CFB), 24'(640 << CFB), 24'(200 << CFB));
      send(24'(700 << CFB), 24'(200 << CFB), 24'(700 << CFB), 24'(200 << CFB));
      send(24'(639 << CFB), 24'(480 << CFB), 24'(639 << CFB), 24'(480 << CFB));
      send(-24'(50 << CFB), 24'(10 << CFB), 24'(800 << CFB), 24'(470 << CFB));
      send(24'(800 << CFB), 24'(470 << CFB), -24'(50 << CFB), 24'(10 << CFB));
      send(24'(10 << CFB), -24'(5 << CFB), 24'(10 << CFB), 24'(600 << CFB));
      send(-24'(10 << CFB), -24'(10 << CFB), 24'(900 << CFB), -24'(1 << CFB));
      send(24'h000001, 24'h000001, 24'h000101, 24'h000003);
      req_valid <= 0;
      drain();
      set_rect(4095, 4095, 4095, 4095);
      send(24'(4095 << CFB), 24'(4095 << CFB), 24'(4095 << CFB), 24'(4095 << CFB));
      send(24'h7fffff, 24'h7fffff, 24'h000000, 24'h000000);
      req_valid <= 0;
      drain();
      set_rect(300, 200, 100, 50); // inverted
      send(24'(150 << CFB), 24'(100 << CFB), 24'(250 << CFB), 24'(40 << CFB));
      send(24'h000000, 24'h000000, 24'h7fffff, 24'h7fffff);
      req_valid <= 0;
      drain();

      set_rect(0, 0, 640, 480);
      random_burst(250);
      // long receiver hold while requests keep coming
      hold_req = 1;
      random_burst(150);
      drain();
      set_rect(0, 0, 0, 0);
      random_burst(60);
      drain();
      set_rect(100, 50, 3000, 4095);
      random_burst(200);
      drain();
      set_rect($urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 4095));
      random_burst(100);
      drain();
      set_rect(0, 0, 4095, 4095);
      random_burst(170);
      drain();

      $display("%0d segments sent, %0d responses checked, 8 clip rectangles, %0d long holds",
               sent, sb.checked, long_hold);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

### filelist.f
rtl/lbc_pkg.sv
rtl/lbc_div.sv
rtl/parametric_line_clipper.sv
sim/tb_parametric_line_clipper.sv
